// ===== rtl/core/gzhp_pkg.sv =====
// gzip header parser package: phase and status codes, flag record, result record
// and the next-field selection shared by the parser core and the top level.
// no dependencies
package gzhp_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam int LEN_W           = 32;

  localparam logic [7:0] MAGIC0    = 8'h1f;
  localparam logic [7:0] MAGIC1    = 8'h8b;
  localparam logic [7:0] METHOD    = 8'h08;
  localparam int         FIXED_LEN = 10;
  localparam logic [15:0] HCRC_LEN = 16'd2;

  // bit positions inside the flag byte
  localparam int FHCRC_BIT    = 1;
  localparam int FEXTRA_BIT   = 2;
  localparam int FNAME_BIT    = 3;
  localparam int FCOMMENT_BIT = 4;

  typedef enum logic [2:0] {
    PH_FIXED   = 3'd0,
    PH_XLO     = 3'd1,
    PH_XHI     = 3'd2,
    PH_XSKIP   = 3'd3,
    PH_NAME    = 3'd4,
    PH_COMMENT = 3'd5,
    PH_HCRC    = 3'd6,
    PH_DONE    = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MAGIC = 2'd1,
    ST_TRUNC = 2'd2,
    ST_OVFL  = 2'd3
  } status_e;

  typedef struct packed {
    logic fcomment;
    logic fname;
    logic fextra;
    logic fhcrc;
  } flags_t;

  typedef struct packed {
    status_e           status;
    logic [LEN_W-1:0]  length;
  } res_t;

  // optional fields come in a fixed order; pick the first one still ahead
  function automatic phase_e next_stage(phase_e from, flags_t f);
    phase_e nxt;
    nxt = PH_DONE;
    if (from < PH_HCRC && f.fhcrc)
      nxt = PH_HCRC;
    if (from < PH_COMMENT && f.fcomment)
      nxt = PH_COMMENT;
    if (from < PH_NAME && f.fname)
      nxt = PH_NAME;
    if (from < PH_XLO && f.fextra)
      nxt = PH_XLO;
    return nxt;
  endfunction

endpackage

// ===== rtl/core/gzip_header_parser.sv =====
// gzip header parser top level: stream ports, parser core and result register.
// one byte per cycle; a result beat appears in the cycle after the byte that decides it
// and the input is held off only while that beat waits and the master side is stalled.
// rst_ni clears all parser state and the pending result; throughput is one beat per cycle.
// depends on gzhp_pkg, gzhp_parse, gzhp_out_reg
module gzip_header_parser #(
  parameter int OFFSET_BITS = gzhp_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] header_length
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  logic           beat;
  logic           emit;
  logic           free;
  gzhp_pkg::res_t res;
  gzhp_pkg::res_t res_out;

  assign s_axis_tready = free;
  assign beat          = s_axis_tvalid && free;

  gzhp_parse #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (beat),
    .data_i (s_axis_tdata),
    .last_i (s_axis_tlast),
    .emit_o (emit),
    .res_o  (res)
  );

  gzhp_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (emit),
    .res_i   (res),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .res_o   (res_out),
    .free_o  (free)
  );

  assign m_axis_tdata = res_out.length;
  assign m_axis_tuser = res_out.status;

endmodule

// ===== rtl/core/gzhp_parse.sv =====
// gzip header parser core: per-stream state registers and the per-byte update.
// decides at most one result per accepted byte.
// depends on gzhp_pkg
module gzhp_parse #(
  parameter int OFFSET_BITS = gzhp_pkg::OFFSET_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              beat_i,
  input  logic [7:0]        data_i,
  input  logic              last_i,
  output logic              emit_o,
  output gzhp_pkg::res_t    res_o
);

  localparam int CntW = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;

  gzhp_pkg::phase_e phase_q, phase_d;
  logic [CntW-1:0]  pos_q, pos_d;
  gzhp_pkg::flags_t flags_q, flags_d;
  logic [7:0]       xlo_q, xlo_d;
  logic [15:0]      skip_q, skip_d;
  logic             given_q, given_d;
  logic             clear;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    flags_d = flags_q;
    xlo_d   = xlo_q;
    skip_d  = skip_q;
    given_d = given_q;
    clear   = 1'b0;
    emit_o  = 1'b0;
    res_o.status = gzhp_pkg::ST_OK;
    res_o.length = '0;

    if (beat_i) begin
      if (given_q) begin
        // waiting for the end of the stream
        clear = last_i;
      end else begin
        if (pos_q == '1) begin
          emit_o = 1'b1;
          res_o.status = gzhp_pkg::ST_OVFL;
        end else begin
          pos_d = pos_q + CntW'(1);
          case (phase_q)
            gzhp_pkg::PH_FIXED: begin
              if ((pos_q == CntW'(0) && data_i != gzhp_pkg::MAGIC0) ||
                  (pos_q == CntW'(1) && data_i != gzhp_pkg::MAGIC1) ||
                  (pos_q == CntW'(2) && data_i != gzhp_pkg::METHOD)) begin
                emit_o = 1'b1;
                res_o.status = gzhp_pkg::ST_MAGIC;
              end else if (pos_q == CntW'(3)) begin
                flags_d.fhcrc    = data_i[gzhp_pkg::FHCRC_BIT];
                flags_d.fextra   = data_i[gzhp_pkg::FEXTRA_BIT];
                flags_d.fname    = data_i[gzhp_pkg::FNAME_BIT];
                flags_d.fcomment = data_i[gzhp_pkg::FCOMMENT_BIT];
              end else if (pos_q >= CntW'(gzhp_pkg::FIXED_LEN - 1)) begin
                phase_d = gzhp_pkg::next_stage(gzhp_pkg::PH_FIXED, flags_q);
              end
            end
            gzhp_pkg::PH_XLO: begin
              xlo_d   = data_i;
              phase_d = gzhp_pkg::PH_XHI;
            end
            gzhp_pkg::PH_XHI: begin
              skip_d  = {data_i, xlo_q};
              phase_d = (skip_d == '0) ?
                        gzhp_pkg::next_stage(gzhp_pkg::PH_XSKIP, flags_q) :
                        gzhp_pkg::PH_XSKIP;
            end
            gzhp_pkg::PH_XSKIP: begin
              skip_d = skip_q - 16'd1;
              if (skip_d == '0)
                phase_d = gzhp_pkg::next_stage(gzhp_pkg::PH_XSKIP, flags_q);
            end
            gzhp_pkg::PH_NAME: begin
              if (data_i == '0)
                phase_d = gzhp_pkg::next_stage(gzhp_pkg::PH_NAME, flags_q);
            end
            gzhp_pkg::PH_COMMENT: begin
              if (data_i == '0)
                phase_d = gzhp_pkg::next_stage(gzhp_pkg::PH_COMMENT, flags_q);
            end
            gzhp_pkg::PH_HCRC: begin
              skip_d = skip_q - 16'd1;
              if (skip_d == '0)
                phase_d = gzhp_pkg::PH_DONE;
            end
            default: begin
              phase_d = gzhp_pkg::PH_DONE;
            end
          endcase

          // entering the header crc loads its byte count
          if (phase_d == gzhp_pkg::PH_HCRC && phase_q != gzhp_pkg::PH_HCRC)
            skip_d = gzhp_pkg::HCRC_LEN;

          if (!emit_o) begin
            if (phase_d == gzhp_pkg::PH_DONE) begin
              emit_o = 1'b1;
              res_o.status = gzhp_pkg::ST_OK;
              res_o.length = gzhp_pkg::LEN_W'(pos_d);
            end else if (last_i) begin
              emit_o = 1'b1;
              res_o.status = gzhp_pkg::ST_TRUNC;
            end
          end
        end

        if (emit_o) begin
          clear   = last_i;
          given_d = 1'b1;
        end
      end
    end

    if (clear) begin
      phase_d = gzhp_pkg::PH_FIXED;
      pos_d   = '0;
      flags_d = '0;
      xlo_d   = '0;
      skip_d  = '0;
      given_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= gzhp_pkg::PH_FIXED;
      pos_q   <= '0;
      flags_q <= '0;
      xlo_q   <= '0;
      skip_q  <= '0;
      given_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      flags_q <= flags_d;
      xlo_q   <= xlo_d;
      skip_q  <= skip_d;
      given_q <= given_d;
    end
  end

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i && last_i |=> pos_q == '0 && !given_q && phase_q == gzhp_pkg::PH_FIXED)
    else $error("stream end did not restart the parser");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i && given_q |-> !emit_o)
    else $error("second result in one stream");

  a_ok_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o && res_o.status == gzhp_pkg::ST_OK |->
      res_o.length >= gzhp_pkg::LEN_W'(gzhp_pkg::FIXED_LEN))
    else $error("ok result shorter than the fixed header");

  a_err_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o && res_o.status != gzhp_pkg::ST_OK |-> res_o.length == '0)
    else $error("error result carries a length");

endmodule

// ===== rtl/core/gzhp_out_reg.sv =====
// gzip header parser result register: holds one result beat for the master side.
// depends on gzhp_pkg
module gzhp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  gzhp_pkg::res_t    res_i,
  input  logic              ready_i,
  output logic              valid_o,
  output gzhp_pkg::res_t    res_o,
  output logic              free_o
);

  logic           valid_q, valid_d;
  gzhp_pkg::res_t res_q;

  // a waiting beat leaves in the same cycle a new one can land
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i)
      valid_d = 1'b1;
    else if (ready_i)
      valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
